FILE: design/button_multi_press_detector_macros.svh
// ----------------------------------------------------------------------------
// Button multi-press detector assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_MULTI_PRESS_DETECTOR_MACROS_SVH
`define BUTTON_MULTI_PRESS_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMPD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// Button multi-press detector package
// Widths, register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
package bmpd_pkg;

   localparam int NOW_W   = 32;
   localparam int TIME_W  = 16;
   localparam int EN_W    = 5;
   localparam int COUNT_W = 8;
   localparam int INDEX_W = 3;

   localparam logic [INDEX_W-1:0] REG_TOGGLE_MODE   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_EVENT_ENABLE  = 3'd1;
   localparam logic [INDEX_W-1:0] REG_DOUBLE_TMO    = 3'd2;
   localparam logic [INDEX_W-1:0] REG_TRIPLE_TMO    = 3'd3;
   localparam logic [INDEX_W-1:0] REG_LONG_TMO      = 3'd4;
   localparam logic [INDEX_W-1:0] REG_REPEAT_IVL    = 3'd5;

   localparam int EN_SINGLE = 0;
   localparam int EN_DOUBLE = 1;
   localparam int EN_TRIPLE = 2;
   localparam int EN_LONG   = 3;
   localparam int EN_REPEAT = 4;

   localparam logic [TIME_W-1:0] DOUBLE_TMO_RESET = 16'd300;
   localparam logic [TIME_W-1:0] TRIPLE_TMO_RESET = 16'd500;
   localparam logic [TIME_W-1:0] LONG_TMO_RESET   = 16'd1000;
   localparam logic [TIME_W-1:0] REPEAT_IVL_RESET = 16'd200;

   localparam logic [COUNT_W-1:0] COUNT_SINGLE = 8'd1;
   localparam logic [COUNT_W-1:0] COUNT_DOUBLE = 8'd2;
   localparam logic [COUNT_W-1:0] COUNT_TRIPLE = 8'd3;

   typedef struct packed {
      logic toggle_event;
      logic toggle_level;
      logic single_event;
      logic double_event;
      logic triple_event;
      logic long_event;
      logic repeat_event;
   } rsp_type;

endpackage

FILE: design/bmpd_channels.sv
// ----------------------------------------------------------------------------
// Button multi-press detector channels
// Valid/ready channels for poll requests and event responses.
// ----------------------------------------------------------------------------
interface bmpd_req_if import bmpd_pkg::*;;
   logic             valid;
   logic             ready;
   logic             pressed;
   logic [NOW_W-1:0] now_ms;

   modport source (output valid, output pressed, output now_ms, input ready);
   modport sink   (input valid, input pressed, input now_ms, output ready);
endinterface

interface bmpd_rsp_if;
   logic valid;
   logic ready;
   logic toggle_event;
   logic toggle_level;
   logic single_event;
   logic double_event;
   logic triple_event;
   logic long_event;
   logic repeat_event;

   modport source (output valid, output toggle_event, output toggle_level,
                   output single_event, output double_event, output triple_event,
                   output long_event, output repeat_event, input ready);
   modport sink   (input valid, input toggle_event, input toggle_level,
                   input single_event, input double_event, input triple_event,
                   input long_event, input repeat_event, output ready);
endinterface

FILE: design/button_multi_press_detector.sv
// Pipeline: a request passes from the request register to the response register.
// Throughput: one request per cycle unless the response stalls; the press state is
// updated in the single evaluation stage between the request and response registers.
// Reset: synchronous, active high; clears both stage valids, the press state,
// and loads the default enables and timeouts.
// ----------------------------------------------------------------------------
// Button multi-press detector
// Classifies button polls into toggle, single, double, triple, long and repeat
// events, one response per request.
// ----------------------------------------------------------------------------
`include "button_multi_press_detector_macros.svh"

module button_multi_press_detector import bmpd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   bmpd_req_if.sink           req_ch,
   bmpd_rsp_if.source         rsp_ch,
   input  logic               csr_we,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]  csr_wdata
);

   logic               toggle_mode_ff;
   logic [EN_W-1:0]    event_enable_ff;
   logic [TIME_W-1:0]  double_tmo_ff;
   logic [TIME_W-1:0]  triple_tmo_ff;
   logic [TIME_W-1:0]  long_tmo_ff;
   logic [TIME_W-1:0]  repeat_ivl_ff;

   logic               s1_valid_ff;
   logic               s1_pressed_ff;
   logic [NOW_W-1:0]   s1_now_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               was_pressed_ff, was_pressed_in;
   logic [NOW_W-1:0]   press_start_ff, press_start_in;
   logic [NOW_W-1:0]   last_release_ff, last_release_in;
   logic [NOW_W-1:0]   last_repeat_ff, last_repeat_in;
   logic [COUNT_W-1:0] press_count_ff, press_count_in;
   rsp_type            rsp_in;

   logic               advance;
   logic               process;
   logic               press_edge;
   logic               release_edge;
   logic [NOW_W-1:0]   since_rel;
   logic [NOW_W-1:0]   held;
   logic [NOW_W-1:0]   repeat_base;
   logic [NOW_W-1:0]   repeat_gap;
   logic [COUNT_W-1:0] count;
   logic [NOW_W-1:0]   double_lim;
   logic [NOW_W-1:0]   triple_lim;
   logic [NOW_W-1:0]   long_lim;
   logic [NOW_W-1:0]   repeat_lim;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign process      = s1_valid_ff && advance;
   assign req_ch.ready = !s1_valid_ff || advance;

   assign double_lim = {{(NOW_W-TIME_W){1'b0}}, double_tmo_ff};
   assign triple_lim = {{(NOW_W-TIME_W){1'b0}}, triple_tmo_ff};
   assign long_lim   = {{(NOW_W-TIME_W){1'b0}}, long_tmo_ff};
   assign repeat_lim = {{(NOW_W-TIME_W){1'b0}}, repeat_ivl_ff};

   assign since_rel    = s1_now_ff - last_release_ff;
   assign held         = s1_now_ff - press_start_ff;
   assign press_edge   = s1_pressed_ff && !was_pressed_ff;
   assign release_edge = !s1_pressed_ff && was_pressed_ff;

   always_comb begin
      was_pressed_in  = was_pressed_ff;
      press_start_in  = press_start_ff;
      last_release_in = last_release_ff;
      last_repeat_in  = last_repeat_ff;
      press_count_in  = press_count_ff;
      rsp_in          = '0;
      count           = press_count_ff;
      repeat_base     = last_repeat_ff;
      repeat_gap      = '0;
      if (toggle_mode_ff) begin
         if (s1_pressed_ff != was_pressed_ff) begin
            was_pressed_in      = s1_pressed_ff;
            rsp_in.toggle_event = 1'b1;
            rsp_in.toggle_level = s1_pressed_ff;
         end
      end else begin
         if (press_edge) begin
            press_start_in = s1_now_ff;
            was_pressed_in = 1'b1;
            count          = press_count_ff + COUNT_SINGLE;
            if (since_rel <= double_lim && count == COUNT_DOUBLE) begin
               rsp_in.double_event = event_enable_ff[EN_DOUBLE];
            end
            if (since_rel <= triple_lim && count == COUNT_TRIPLE) begin
               rsp_in.triple_event = event_enable_ff[EN_TRIPLE];
               count               = '0;
            end
            repeat_base = s1_now_ff;
         end
         if (release_edge) begin
            if (held < long_lim) begin
               if (event_enable_ff[EN_SINGLE] && count == COUNT_SINGLE) begin
                  last_release_in = s1_now_ff;
               end
            end else begin
               rsp_in.long_event = event_enable_ff[EN_LONG];
               count             = '0;
            end
            was_pressed_in = 1'b0;
         end
         if (count == COUNT_SINGLE && !s1_pressed_ff && since_rel > double_lim) begin
            rsp_in.single_event = event_enable_ff[EN_SINGLE];
            count               = '0;
         end
         last_repeat_in = repeat_base;
         repeat_gap     = s1_now_ff - repeat_base;
         if (s1_pressed_ff && event_enable_ff[EN_REPEAT] && repeat_gap >= repeat_lim) begin
            rsp_in.repeat_event = 1'b1;
            last_repeat_in      = s1_now_ff;
         end
         press_count_in = count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         toggle_mode_ff  <= 1'b0;
         event_enable_ff <= '0;
         double_tmo_ff   <= DOUBLE_TMO_RESET;
         triple_tmo_ff   <= TRIPLE_TMO_RESET;
         long_tmo_ff     <= LONG_TMO_RESET;
         repeat_ivl_ff   <= REPEAT_IVL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TOGGLE_MODE:  toggle_mode_ff  <= csr_wdata[0];
            REG_EVENT_ENABLE: event_enable_ff <= csr_wdata[EN_W-1:0];
            REG_DOUBLE_TMO:   double_tmo_ff   <= csr_wdata;
            REG_TRIPLE_TMO:   triple_tmo_ff   <= csr_wdata;
            REG_LONG_TMO:     long_tmo_ff     <= csr_wdata;
            REG_REPEAT_IVL:   repeat_ivl_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         was_pressed_ff  <= 1'b0;
         press_start_ff  <= '0;
         last_release_ff <= '0;
         last_repeat_ff  <= '0;
         press_count_ff  <= '0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (process) begin
            was_pressed_ff  <= was_pressed_in;
            press_start_ff  <= press_start_in;
            last_release_ff <= last_release_in;
            last_repeat_ff  <= last_repeat_in;
            press_count_ff  <= press_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_pressed_ff <= req_ch.pressed;
         s1_now_ff     <= req_ch.now_ms;
      end
      if (process) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.toggle_event = rsp_ff.toggle_event;
   assign rsp_ch.toggle_level = rsp_ff.toggle_level;
   assign rsp_ch.single_event = rsp_ff.single_event;
   assign rsp_ch.double_event = rsp_ff.double_event;
   assign rsp_ch.triple_event = rsp_ff.triple_event;
   assign rsp_ch.long_event   = rsp_ff.long_event;
   assign rsp_ch.repeat_event = rsp_ff.repeat_event;

   `BMPD_ASSERT_SAME(a_ready_when_empty, !rsp_valid_ff, req_ch.ready,
      "Request not accepted while the response register is empty")
   `BMPD_ASSERT_SAME(a_single_double_apart, rsp_valid_ff,
      !(rsp_ff.single_event && rsp_ff.double_event),
      "Single and double events flagged in the same response")
   `BMPD_ASSERT_NEXT(a_level_tracked, process && !toggle_mode_ff,
      was_pressed_ff == $past(s1_pressed_ff),
      "Button level not tracked after a request")
   `BMPD_ASSERT_NEXT(a_triple_clears_count, process && rsp_in.triple_event,
      press_count_ff == '0,
      "Press count not cleared after a triple press")

endmodule
